// ----- hdl/assert_macros.svh -----
// Assertion helpers for the odometry block.
// ASSERT_CHK: concurrent check on clk, disabled while rst_n is low.
// ASSERT_CHK_ANY: concurrent check on clk that also holds during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CHK_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CHK(label, prop, msg)
`define ASSERT_CHK_ANY(label, prop, msg)
`endif
`endif

// ----- hdl/dd_odo_pkg.sv -----
package dd_odo_pkg;

  // configuration register indexes
  localparam logic REG_DIST_PER_COUNT  = 1'b0;
  localparam logic REG_ANGLE_PER_COUNT = 1'b1;

  // angle constants, Q4.28, sign-extended to the 34-bit working width
  localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
  localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
  localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;

  // CORDIC start value (inverse gain), Q2.30
  localparam logic signed [33:0] CORDIC_X0 = 34'sh026DD3B6A;

  localparam logic [47:0] MAX48 = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] MIN48 = 48'h8000_0000_0000;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic       load;      // input transfer: capture deltas, reduce heading
    logic       mac;       // multiply phase active
    logic       scale_ph;  // 0: angle/distance products, 1: cos/sin scaling
    logic [2:0] k;         // sub-step inside a multiply phase
    logic       step;      // one CORDIC iteration
    logic [4:0] iter;      // CORDIC iteration index
    logic       commit;    // update pose and load the output register
  } cmd_t;

  typedef struct packed {
    logic out_blocked;     // output register full and stalled
  } status_t;

  // arctangent of 2^-i, Q2.30
  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] v;
    case (i)
      5'd0:  v = 31'h3243F6A8;
      5'd1:  v = 31'h1DAC6705;
      5'd2:  v = 31'h0FADBAFC;
      5'd3:  v = 31'h07F56EA6;
      5'd4:  v = 31'h03FEAB76;
      5'd5:  v = 31'h01FFD55B;
      5'd6:  v = 31'h00FFFAAA;
      5'd7:  v = 31'h007FFF55;
      5'd8:  v = 31'h003FFFEA;
      5'd9:  v = 31'h001FFFFD;
      5'd10: v = 31'h000FFFFF;
      5'd11: v = 31'h0007FFFF;
      5'd12: v = 31'h0003FFFF;
      5'd13: v = 31'h0001FFFF;
      5'd14: v = 31'h0000FFFF;
      5'd15: v = 31'h00007FFF;
      5'd16: v = 31'h00003FFF;
      5'd17: v = 31'h00001FFF;
      5'd18: v = 31'h00000FFF;
      5'd19: v = 31'h000007FF;
      5'd20: v = 31'h000003FF;
      5'd21: v = 31'h000001FF;
      5'd22: v = 31'h000000FF;
      5'd23: v = 31'h0000007F;
      5'd24: v = 31'h0000003F;
      5'd25: v = 31'h0000001F;
      5'd26: v = 31'h0000000F;
      5'd27: v = 31'h00000008;
      5'd28: v = 31'h00000004;
      5'd29: v = 31'h00000002;
      5'd30: v = 31'h00000001;
      default: v = 31'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/dd_odo_ctrl.sv -----
`include "assert_macros.svh"

module dd_odo_ctrl import dd_odo_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [4:0] LAST_ITER = 5'(CORDIC_STEPS - 1);
  localparam logic [2:0] LAST_K    = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CORDIC,
    S_SCALE,
    S_COMMIT
  } state_t;

  state_t     state_r;
  logic [2:0] k_r;
  logic [4:0] iter_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      iter_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_MUL;
            k_r     <= '0;
          end
        end
        S_MUL: begin
          if (k_r == LAST_K) begin
            state_r <= S_CORDIC;
            iter_r  <= '0;
          end else begin
            k_r <= k_r + 3'd1;
          end
        end
        S_CORDIC: begin
          if (iter_r == LAST_ITER) begin
            state_r <= S_SCALE;
            k_r     <= '0;
          end else begin
            iter_r <= iter_r + 5'd1;
          end
        end
        S_SCALE: begin
          if (k_r == LAST_K) begin
            state_r <= S_COMMIT;
          end else begin
            k_r <= k_r + 3'd1;
          end
        end
        S_COMMIT: begin
          if (!status.out_blocked) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // command decode
  assign in_stall     = (state_r != S_IDLE);
  assign cmd.load     = (state_r == S_IDLE) && in_valid;
  assign cmd.mac      = (state_r == S_MUL) || (state_r == S_SCALE);
  assign cmd.scale_ph = (state_r == S_SCALE);
  assign cmd.k        = k_r;
  assign cmd.step     = (state_r == S_CORDIC);
  assign cmd.iter     = iter_r;
  assign cmd.commit   = (state_r == S_COMMIT) && !status.out_blocked;

  `ASSERT_CHK(a_load_starts_mul, cmd.load |=> (cmd.mac && !cmd.scale_ph && cmd.k == 3'd0),
              "load not followed by first multiply step")
  `ASSERT_CHK(a_commit_frees, cmd.commit |=> !in_stall, "commit did not return to idle")
  `ASSERT_CHK(a_scale_after_cordic, $rose(cmd.scale_ph) |-> $past(cmd.step),
              "scaling began without CORDIC")
  `ASSERT_CHK(a_commit_not_blocked, cmd.commit |-> !status.out_blocked,
              "commit into a stalled output")

endmodule

// ----- hdl/dd_odo_dp.sv -----
module dd_odo_dp import dd_odo_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic signed [31:0] in_left_total,
  input  logic signed [31:0] in_right_total,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_pos_x,
  output logic signed [47:0] out_pos_y,
  output logic signed [31:0] out_heading,
  output logic signed [47:0] out_step_x,
  output logic signed [47:0] out_step_y,
  output logic signed [31:0] out_step_heading
);

  // configuration and pose state
  logic [31:0] dpc_r, apc_r;
  logic [31:0] last_left_r, last_right_r;
  logic [47:0] acc_x_r, acc_y_r;
  logic [31:0] acc_h_r;

  // per-item working registers
  logic [32:0] diff_mag_r, sum_mag_r;
  logic        diff_neg_r, sum_neg_r, flip_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic [63:0] p_r, pa_r;
  logic [31:0] dth_r;
  logic [46:0] dmag_r;
  logic [47:0] sx_r, sy_r;

  // output register
  logic        out_valid_r;
  logic [47:0] o_x_r, o_y_r, o_sx_r, o_sy_r;
  logic [31:0] o_h_r, o_dth_r;

  // ---- input deltas and heading reduction ----
  logic [31:0] dl, dr;
  logic [33:0] diff_v, sum_v;
  logic [32:0] diff_m, sum_m;
  logic signed [33:0] t0, t1, t2;
  logic        flip_v;

  always_comb begin
    dl     = in_left_total - last_left_r;
    dr     = in_right_total - last_right_r;
    diff_v = {{2{dr[31]}}, dr} - {{2{dl[31]}}, dl};
    sum_v  = {{2{dr[31]}}, dr} + {{2{dl[31]}}, dl};
    diff_m = diff_v[33] ? 33'(34'd0 - diff_v) : diff_v[32:0];
    sum_m  = sum_v[33] ? 33'(34'd0 - sum_v) : sum_v[32:0];
    t0 = {{2{acc_h_r[31]}}, acc_h_r};
    if (t0 > PI_Q28) begin
      t1 = t0 - TWO_PI_Q28;
    end else if (t0 < -PI_Q28) begin
      t1 = t0 + TWO_PI_Q28;
    end else begin
      t1 = t0;
    end
    flip_v = 1'b1;
    if (t1 > HALF_PI_Q28) begin
      t2 = t1 - PI_Q28;
    end else if (t1 < -HALF_PI_Q28) begin
      t2 = t1 + PI_Q28;
    end else begin
      t2 = t1;
      flip_v = 1'b0;
    end
  end

  // ---- shared multiplier operand select ----
  logic [30:0] cmag, smag;
  logic [32:0] mul_a;
  logic [30:0] mul_b;
  logic [63:0] mul_p;

  always_comb begin
    cmag = x_r[33] ? 31'(-x_r) : x_r[30:0];
    smag = y_r[33] ? 31'(-y_r) : y_r[30:0];
    mul_a = '0;
    mul_b = '0;
    if (!cmd.scale_ph) begin
      case (cmd.k)
        3'd0: begin mul_a = diff_mag_r; mul_b = {15'd0, apc_r[31:16]}; end
        3'd1: begin mul_a = diff_mag_r; mul_b = {15'd0, apc_r[15:0]}; end
        3'd2: begin mul_a = sum_mag_r;  mul_b = {15'd0, dpc_r[31:16]}; end
        3'd3: begin mul_a = sum_mag_r;  mul_b = {15'd0, dpc_r[15:0]}; end
        default: ;
      endcase
    end else begin
      case (cmd.k)
        3'd0: begin mul_a = {10'd0, dmag_r[46:24]}; mul_b = cmag; end
        3'd1: begin mul_a = {9'd0, dmag_r[23:0]};   mul_b = cmag; end
        3'd2: begin mul_a = {10'd0, dmag_r[46:24]}; mul_b = smag; end
        3'd3: begin mul_a = {9'd0, dmag_r[23:0]};   mul_b = smag; end
        default: ;
      endcase
    end
    mul_p = {31'd0, mul_a} * {33'd0, mul_b};
  end

  // ---- combine partial products ----
  logic        ang_sat;
  logic [49:0] ang_sum;
  logic [45:0] ang_q;
  logic [31:0] dth_v;
  logic [64:0] dist_full;
  logic [55:0] sc_inner;
  logic [48:0] sc_r;
  logic        sc_neg;
  logic [47:0] sc_v;

  always_comb begin
    // heading change, saturated
    ang_sat = |pa_r[63:20];
    ang_sum = {14'd0, pa_r[19:0], 16'd0} + {1'b0, p_r[48:0]};
    ang_q   = ang_sum[49:4];
    if (diff_neg_r) begin
      dth_v = (ang_sat || ang_q > 46'h80000000) ? 32'h80000000 : (32'd0 - ang_q[31:0]);
    end else begin
      dth_v = (ang_sat || ang_q > 46'h7FFFFFFF) ? 32'h7FFFFFFF : ang_q[31:0];
    end
    // distance magnitude
    dist_full = {pa_r[48:0], 16'd0} + {16'd0, p_r[48:0]};
    // distance times cos or sin, saturated
    sc_inner = {26'd0, pa_r[5:0], 24'd0} + {1'b0, p_r[54:0]};
    sc_r     = {1'b0, pa_r[53:6]} + {23'd0, sc_inner[55:30]};
    sc_neg   = sum_neg_r ^ flip_r ^ (cmd.k == 3'd2 ? x_r[33] : y_r[33]);
    if (sc_neg) begin
      sc_v = (sc_r > {1'b0, MIN48}) ? MIN48 : (48'd0 - sc_r[47:0]);
    end else begin
      sc_v = (sc_r > {1'b0, MAX48}) ? MAX48 : sc_r[47:0];
    end
  end

  // ---- CORDIC iteration ----
  logic signed [33:0] xs, ys, atn;
  always_comb begin
    xs  = x_r >>> cmd.iter;
    ys  = y_r >>> cmd.iter;
    atn = {3'd0, atan_q30(cmd.iter)};
  end

  // ---- pose update ----
  logic signed [33:0] h_sum, h_wrap;
  logic [31:0] h_v;
  always_comb begin
    h_sum = {{2{acc_h_r[31]}}, acc_h_r} + {{2{dth_r[31]}}, dth_r};
    if (h_sum > TWO_PI_Q28) begin
      h_wrap = h_sum - TWO_PI_Q28;
    end else if (h_sum <= -TWO_PI_Q28) begin
      h_wrap = h_sum + TWO_PI_Q28;
    end else begin
      h_wrap = h_sum;
    end
    if (h_wrap > 34'sh07FFFFFFF) begin
      h_v = 32'h7FFFFFFF;
    end else if (h_wrap < -34'sh080000000) begin
      h_v = 32'h80000000;
    end else begin
      h_v = h_wrap[31:0];
    end
  end

  // config, pose state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpc_r        <= '0;
      apc_r        <= '0;
      last_left_r  <= '0;
      last_right_r <= '0;
      acc_x_r      <= '0;
      acc_y_r      <= '0;
      acc_h_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DIST_PER_COUNT:  dpc_r <= cfg_wdata;
          REG_ANGLE_PER_COUNT: apc_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load) begin
        last_left_r  <= in_left_total;
        last_right_r <= in_right_total;
      end
      if (cmd.commit) begin
        acc_x_r     <= acc_x_r + sx_r;
        acc_y_r     <= acc_y_r + sy_r;
        acc_h_r     <= h_v;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      diff_mag_r <= diff_m;
      diff_neg_r <= diff_v[33];
      sum_mag_r  <= sum_m;
      sum_neg_r  <= sum_v[33];
      flip_r     <= flip_v;
      x_r        <= CORDIC_X0;
      y_r        <= '0;
      z_r        <= t2 <<< 2;
    end
    if (cmd.step) begin
      if (!z_r[33]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atn;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atn;
      end
    end
    if (cmd.mac) begin
      p_r <= mul_p;
      if (cmd.k == 3'd1 || cmd.k == 3'd3) begin
        pa_r <= p_r;
      end
      if (cmd.k == 3'd2) begin
        if (cmd.scale_ph) begin
          sx_r <= sc_v;
        end else begin
          dth_r <= dth_v;
        end
      end
      if (cmd.k == 3'd4) begin
        if (cmd.scale_ph) begin
          sy_r <= sc_v;
        end else begin
          dmag_r <= dist_full[63:17];
        end
      end
    end
    if (cmd.commit) begin
      o_x_r   <= acc_x_r + sx_r;
      o_y_r   <= acc_y_r + sy_r;
      o_h_r   <= h_v;
      o_sx_r  <= sx_r;
      o_sy_r  <= sy_r;
      o_dth_r <= dth_r;
    end
  end

  assign status.out_blocked = out_valid_r && out_stall;
  assign out_valid          = out_valid_r;
  assign out_pos_x          = o_x_r;
  assign out_pos_y          = o_y_r;
  assign out_heading        = o_h_r;
  assign out_step_x         = o_sx_r;
  assign out_step_y         = o_sy_r;
  assign out_step_heading   = o_dth_r;

endmodule

// ----- hdl/differential_drive_odometry.sv -----
// Channel   Handshake              Payload
// input     in_valid / in_stall    in_left_total, in_right_total
// result    out_valid / out_stall  out_pos_x/y, out_heading, out_step_x/y, out_step_heading
// config    cfg_we                 cfg_index, cfg_wdata
//
// Each item runs its CORDIC iterations on one shift-add unit and uses one shared
// 33x31 multiplier for four partial products before and four after the CORDIC.
// A new input is taken once the previous item has reached the output register.
// A stalled result holds the pose update until the output register frees up.
// Synchronous active-low reset clears the pose, previous counts and both registers.
module differential_drive_odometry import dd_odo_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_left_total,
  input  logic signed [31:0] in_right_total,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_pos_x,
  output logic signed [47:0] out_pos_y,
  output logic signed [31:0] out_heading,
  output logic signed [47:0] out_step_x,
  output logic signed [47:0] out_step_y,
  output logic signed [31:0] out_step_heading
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  dd_odo_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and pose state
  dd_odo_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_left_total    (in_left_total),
    .in_right_total   (in_right_total),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_heading      (out_heading),
    .out_step_x       (out_step_x),
    .out_step_y       (out_step_y),
    .out_step_heading (out_step_heading)
  );

endmodule
